/* rtl/dtsp_pkg.sv */
// Shared types, constants and helper functions of the date/time string parser.
package dtsp_pkg;

	// Field widths
	localparam int unsigned CharW   = 8;
	localparam int unsigned ValueW  = 21;
	localparam int unsigned MagW    = 20;
	localparam int unsigned ProdW   = 24;
	localparam int unsigned ResW    = 5;
	localparam int unsigned OutW    = 64;

	// Magnitude ceiling of one field, and its residue modulo 25
	localparam logic [MagW-1:0] MagLimit    = 20'd999999;
	localparam logic [ResW-1:0] MagLimitRes = 5'd24;

	// Character codes
	localparam logic [CharW-1:0] ChNul    = 8'h00;
	localparam logic [CharW-1:0] ChTab    = 8'h09;
	localparam logic [CharW-1:0] ChCr     = 8'h0D;
	localparam logic [CharW-1:0] ChSpace  = 8'h20;
	localparam logic [CharW-1:0] ChPlus   = 8'h2B;
	localparam logic [CharW-1:0] ChMinus  = 8'h2D;
	localparam logic [CharW-1:0] ChDot    = 8'h2E;
	localparam logic [CharW-1:0] ChZero   = 8'h30;
	localparam logic [CharW-1:0] ChNine   = 8'h39;
	localparam logic [CharW-1:0] ChColon  = 8'h3A;

	// Field index codes
	localparam logic [1:0] FldFirst  = 2'd0;
	localparam logic [1:0] FldSecond = 2'd1;
	localparam logic [1:0] FldThird  = 2'd2;
	localparam logic [1:0] FldClosed = 2'd3;

	// Validation limits
	localparam logic signed [ValueW-1:0] MonthMin    = 21'sd1;
	localparam logic signed [ValueW-1:0] MonthMax    = 21'sd12;
	localparam logic signed [ValueW-1:0] MonthFeb    = 21'sd2;
	localparam logic signed [ValueW-1:0] DayMin      = 21'sd1;
	localparam logic signed [ValueW-1:0] HourLimit   = 21'sd24;
	localparam logic signed [ValueW-1:0] MinSecLimit = 21'sd60;
	localparam logic [4:0]               FebLeapDays = 5'd29;
	localparam logic [4:0]               FebDays     = 5'd28;

	// Format selected by the configuration register
	typedef enum logic {
		FMT_DATE = 1'b0,
		FMT_TIME = 1'b1
	} mode_t;

	// Conversion phase of the current field
	typedef enum logic [3:0] {
		PH_SKIP   = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	// Values handed to the validator
	typedef struct packed {
		mode_t                    mode;
		logic signed [ValueW-1:0] v0;
		logic signed [ValueW-1:0] v1;
		logic signed [ValueW-1:0] v2;
		logic                     year_div25;
	} check_in_t;

	// Days in a month; codes outside 1..12 give zero
	function automatic logic [4:0] days_in_month(input logic [3:0] m);
		logic [4:0] d;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
			4'd2:                                       d = FebDays;
			default:                                    d = 5'd0;
		endcase
		return d;
	endfunction

	// Residue modulo 25 of a value below 250, by reciprocal multiply
	function automatic logic [ResW-1:0] mod25(input logic [7:0] v);
		logic [13:0] p;
		logic [3:0]  q;
		logic [7:0]  r;
		p = {6'b0, v} * 14'd41;
		q = p[13:10];
		r = v - ({4'b0, q} * 8'd25);
		return r[ResW-1:0];
	endfunction

	// Whitespace as the C library knows it
	function automatic logic is_space(input logic [CharW-1:0] c);
		return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
	endfunction

endpackage

/* rtl/date_time_string_parse_validate_unit.sv */
// Top level: character-stream parser for date and time strings with validation.
// When the NUL item that ends a string is accepted, its result is registered into the output
// buffer. Throughput: one character item per cycle while the skid entry is free.
// A two-entry output buffer lets the input side keep running while a result waits; the input
// stalls only when both entries are full.
// Reset (arst_n low) clears the parse state, selects date format and empties the output buffer.
module date_time_string_parse_validate_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [20:0] first_value, [41:21] second_value,
	                               // [62:42] third_value, [63] zero
	output logic [0:0]  m_tuser,   // [0] valid_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data   // format_mode
);

	localparam int unsigned VW = dtsp_pkg::ValueW;

	// Configuration and parse state
	dtsp_pkg::mode_t               mode_q;
	logic [1:0]                    field_q, field_d;
	dtsp_pkg::phase_t              phase_q, phase_d;
	logic                          neg_q, neg_d;
	logic [dtsp_pkg::MagW-1:0]     mag_q, mag_d;
	logic [dtsp_pkg::ResW-1:0]     res_q, res_d;
	logic signed [VW-1:0]          fin0_q, fin0_d;
	logic signed [VW-1:0]          fin1_q, fin1_d;

	// Output buffer: main entry and skid entry
	logic                          out_valid_q;
	logic [dtsp_pkg::OutW-1:0]     out_data_q;
	logic                          out_flag_q;
	logic                          skid_valid_q;
	logic [dtsp_pkg::OutW-1:0]     skid_data_q;
	logic                          skid_flag_q;

	logic                          accept;
	logic                          produce;
	logic [dtsp_pkg::CharW-1:0]    ch;
	logic [dtsp_pkg::CharW-1:0]    delim;
	logic                          is_digit;
	logic [3:0]                    digit;
	logic [dtsp_pkg::ProdW-1:0]    prod;
	logic                          sat;
	logic [7:0]                    res_sum;
	logic signed [VW-1:0]          cur_val;
	dtsp_pkg::check_in_t           chk;
	logic                          ok;
	logic [dtsp_pkg::OutW-1:0]     new_data;

	assign cfg_ready = 1'b1;
	assign s_tready  = !skid_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign ch        = s_tdata;
	assign produce   = accept && (ch == dtsp_pkg::ChNul);

	assign delim    = (mode_q == dtsp_pkg::FMT_TIME) ? dtsp_pkg::ChColon : dtsp_pkg::ChDot;
	assign is_digit = (ch >= dtsp_pkg::ChZero) && (ch <= dtsp_pkg::ChNine);
	assign digit    = 4'(ch - dtsp_pkg::ChZero);

	// Accumulate one decimal digit, saturating, with the running residue mod 25
	assign prod    = ({4'b0, mag_q} * 24'd10) + {20'b0, digit};
	assign sat     = prod > {4'b0, dtsp_pkg::MagLimit};
	assign res_sum = ({3'b0, res_q} * 8'd10) + {4'b0, digit};

	// Signed value of the field in progress
	assign cur_val = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

	// Assemble the three values the string ends with
	always_comb begin
		chk.mode       = mode_q;
		chk.v0         = (field_q == dtsp_pkg::FldFirst) ? cur_val : fin0_q;
		chk.v1         = '0;
		chk.v2         = '0;
		chk.year_div25 = 1'b1;
		if (field_q == dtsp_pkg::FldSecond) begin
			chk.v1 = cur_val;
		end else if (field_q != dtsp_pkg::FldFirst) begin
			chk.v1         = fin1_q;
			chk.v2         = cur_val;
			chk.year_div25 = (res_q == '0);
		end
	end

	dtsp_validate u_validate (
		.chk (chk),
		.ok  (ok)
	);

	assign new_data = {1'b0, chk.v2, chk.v1, chk.v0};

	// Next parse state for an accepted item
	always_comb begin
		field_d = field_q;
		phase_d = phase_q;
		neg_d   = neg_q;
		mag_d   = mag_q;
		res_d   = res_q;
		fin0_d  = fin0_q;
		fin1_d  = fin1_q;
		if (ch == dtsp_pkg::ChNul) begin
			field_d = dtsp_pkg::FldFirst;
			phase_d = dtsp_pkg::PH_SKIP;
			neg_d   = 1'b0;
			mag_d   = '0;
			res_d   = '0;
			fin0_d  = '0;
			fin1_d  = '0;
		end else if (field_q == dtsp_pkg::FldClosed) begin
			// ignore everything up to the end of the string
		end else if (ch == delim) begin
			if (field_q == dtsp_pkg::FldThird) begin
				field_d = dtsp_pkg::FldClosed;
				phase_d = dtsp_pkg::PH_DONE;
			end else begin
				if (field_q == dtsp_pkg::FldFirst) begin
					fin0_d = cur_val;
				end else begin
					fin1_d = cur_val;
				end
				field_d = field_q + 2'd1;
				phase_d = dtsp_pkg::PH_SKIP;
				neg_d   = 1'b0;
				mag_d   = '0;
				res_d   = '0;
			end
		end else if (is_digit) begin
			if (phase_q != dtsp_pkg::PH_DONE) begin
				mag_d   = sat ? dtsp_pkg::MagLimit : prod[dtsp_pkg::MagW-1:0];
				res_d   = sat ? dtsp_pkg::MagLimitRes : dtsp_pkg::mod25(res_sum);
				phase_d = dtsp_pkg::PH_DIGITS;
			end
		end else if ((phase_q == dtsp_pkg::PH_SKIP) && dtsp_pkg::is_space(ch)) begin
			// skip leading whitespace
		end else if ((phase_q == dtsp_pkg::PH_SKIP)
			&& ((ch == dtsp_pkg::ChPlus) || (ch == dtsp_pkg::ChMinus))) begin
			neg_d   = (ch == dtsp_pkg::ChMinus);
			phase_d = dtsp_pkg::PH_SIGN;
		end else begin
			phase_d = dtsp_pkg::PH_DONE;
		end
	end

	// Hold the format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= dtsp_pkg::FMT_DATE;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= dtsp_pkg::mode_t'(cfg_data);
		end
	end

	// Advance the parse state on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_q <= dtsp_pkg::FldFirst;
			phase_q <= dtsp_pkg::PH_SKIP;
			neg_q   <= 1'b0;
			mag_q   <= '0;
			res_q   <= '0;
			fin0_q  <= '0;
			fin1_q  <= '0;
		end else if (accept) begin
			field_q <= field_d;
			phase_q <= phase_d;
			neg_q   <= neg_d;
			mag_q   <= mag_d;
			res_q   <= res_d;
			fin0_q  <= fin0_d;
			fin1_q  <= fin1_d;
		end
	end

	// Output buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && m_tready) begin
			// main entry drains; refill from skid or from a new result
			out_valid_q  <= skid_valid_q || produce;
			skid_valid_q <= 1'b0;
		end else if (produce) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Output buffer payload
	always_ff @(posedge clk) begin
		if (out_valid_q && m_tready) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				out_flag_q <= skid_flag_q;
			end else if (produce) begin
				out_data_q <= new_data;
				out_flag_q <= ok;
			end
		end else if (produce) begin
			if (out_valid_q) begin
				skid_data_q <= new_data;
				skid_flag_q <= ok;
			end else begin
				out_data_q <= new_data;
				out_flag_q <= ok;
			end
		end
	end

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_data_q;
	assign m_tuser[0] = out_flag_q;

endmodule

/* rtl/dtsp_validate.sv */
// Calendar and clock range checks on the three parsed values.
module dtsp_validate (
	input  dtsp_pkg::check_in_t chk,
	output logic                ok
);

	logic       div4;
	logic       div16;
	logic       leap;
	logic       month_ok;
	logic [4:0] limit;
	logic       day_ok;
	logic       date_ok;
	logic       time_ok;

	// Leap rule from low bits and the residue modulo 25
	assign div4  = (chk.v2[1:0] == 2'b00);
	assign div16 = (chk.v2[3:0] == 4'b0000);
	assign leap  = (div4 && !chk.year_div25) || (div16 && chk.year_div25);

	// Check day against the length of the month
	always_comb begin
		month_ok = (chk.v1 >= dtsp_pkg::MonthMin) && (chk.v1 <= dtsp_pkg::MonthMax);
		limit    = dtsp_pkg::days_in_month(chk.v1[3:0]);
		if ((chk.v1 == dtsp_pkg::MonthFeb) && leap) begin
			limit = dtsp_pkg::FebLeapDays;
		end
		day_ok  = (chk.v0 >= dtsp_pkg::DayMin) && (chk.v0 <= $signed({16'b0, limit}));
		date_ok = month_ok && day_ok;
	end

	// Check hour, minute and second ranges
	assign time_ok = (chk.v0 >= 0) && (chk.v0 < dtsp_pkg::HourLimit)
		&& (chk.v1 >= 0) && (chk.v1 < dtsp_pkg::MinSecLimit)
		&& (chk.v2 >= 0) && (chk.v2 < dtsp_pkg::MinSecLimit);

	assign ok = (chk.mode == dtsp_pkg::FMT_TIME) ? time_ok : date_ok;

endmodule

/* rtl/dtsp_checker.sv */
// Port-level checks of the date/time parser and their attachment to the top level.
module dtsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// A stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Input stalls only while a result is pending
	a_stall_pending: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// A string end into an empty output yields a result next cycle
	a_nul_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tdata == 8'h00) && !m_tvalid |=> m_tvalid)
		else $error("missing result after string end");

	// Ordinary characters into an empty output yield nothing
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tvalid && s_tready && (s_tdata == 8'h00)) && !m_tvalid |=> !m_tvalid)
		else $error("result without string end");

endmodule

bind date_time_string_parse_validate_unit dtsp_checker u_dtsp_checker (.*);

/* sim/date_time_string_parse_validate_unit_tb.sv */
// Testbench for the date/time string parser: directed and random strings checked by a scoreboard.
module date_time_string_parse_validate_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dtsp_pkg::*;

	// One parsed string as it leaves the block
	typedef struct {
		logic signed [ValueW-1:0] day_hour;
		logic signed [ValueW-1:0] month_min;
		logic signed [ValueW-1:0] year_sec;
		logic                     ok;
	} fields_t;

	// Tracks the parse state, predicts each string's values and checks the results
	class datetime_predictor;
		mode_t       mode;
		logic [1:0]  fld;
		phase_t      phase;
		bit          neg;
		int unsigned mag;
		int          done_vals[2];
		fields_t     expected_q[$];
		int unsigned mismatches;

		function new();
			mode = FMT_DATE;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			fld = FldFirst;
			phase = PH_SKIP;
			neg = 1'b0;
			mag = 0;
			done_vals = '{0, 0};
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int field_value();
			return neg ? -int'(mag) : int'(mag);
		endfunction

		// Gregorian rule; truncating remainders keep negative years consistent
		function bit leap_year(int y);
			return ((y % 100) != 0 && (y % 4) == 0) || (y % 400) == 0;
		endfunction

		function bit date_valid(int d, int m, int y);
			int lim;
			if (m < 1 || m > 12)
				return 1'b0;
			case (m)
				4, 6, 9, 11: lim = 30;
				2:           lim = leap_year(y) ? 29 : 28;
				default:     lim = 31;
			endcase
			return d >= 1 && d <= lim;
		endfunction

		function bit time_valid(int h, int m, int s);
			return h >= 0 && h < 24 && m >= 0 && m < 60 && s >= 0 && s < 60;
		endfunction

		// Advance the parse state by one accepted character
		function void note_char(logic [CharW-1:0] c);
			logic [CharW-1:0] delim;
			int               v[3];
			int unsigned      acc;
			fields_t          r;
			delim = (mode == FMT_TIME) ? ChColon : ChDot;
			if (c == ChNul) begin
				v = '{0, 0, 0};
				if (fld != FldFirst)
					v[0] = done_vals[0];
				if (fld == FldThird || fld == FldClosed)
					v[1] = done_vals[1];
				case (fld)
					FldFirst:  v[0] = field_value();
					FldSecond: v[1] = field_value();
					default:   v[2] = field_value();
				endcase
				r.day_hour  = ValueW'(v[0]);
				r.month_min = ValueW'(v[1]);
				r.year_sec  = ValueW'(v[2]);
				r.ok = (mode == FMT_TIME) ? time_valid(v[0], v[1], v[2])
				                          : date_valid(v[0], v[1], v[2]);
				expected_q.push_back(r);
				restart();
				return;
			end
			// everything after the closed third field is ignored
			if (fld == FldClosed)
				return;
			if (c == delim) begin
				if (fld != FldThird) begin
					done_vals[fld] = field_value();
					fld++;
					phase = PH_SKIP;
					neg = 1'b0;
					mag = 0;
				end else begin
					fld = FldClosed;
					phase = PH_DONE;
				end
				return;
			end
			if (c >= ChZero && c <= ChNine) begin
				if (phase != PH_DONE) begin
					acc = mag * 10 + (c - ChZero);
					mag = (acc > MagLimit) ? MagLimit : acc;
					phase = PH_DIGITS;
				end
				return;
			end
			if (phase == PH_SKIP) begin
				if (c == ChSpace || (c >= ChTab && c <= ChCr))
					return;
				if (c == ChPlus || c == ChMinus) begin
					neg = (c == ChMinus);
					phase = PH_SIGN;
					return;
				end
			end
			phase = PH_DONE;
		endfunction

		function void flag(string what, fields_t e, fields_t g);
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] %s: expected %0d/%0d/%0d ok=%0b, got %0d/%0d/%0d ok=%0b",
					$realtime, what, e.day_hour, e.month_min, e.year_sec, e.ok,
					g.day_hour, g.month_min, g.year_sec, g.ok);
		endfunction

		// Compare one accepted result against the oldest prediction
		function void check_result(logic [OutW-1:0] d, logic u);
			fields_t e;
			fields_t g;
			g.day_hour  = d[20:0];
			g.month_min = d[41:21];
			g.year_sec  = d[62:42];
			g.ok        = u;
			if (expected_q.size() == 0) begin
				flag("result with no string pending", g, g);
				return;
			end
			e = expected_q.pop_front();
			if (g.day_hour !== e.day_hour || g.month_min !== e.month_min ||
			    g.year_sec !== e.year_sec || g.ok !== e.ok)
				flag("value mismatch", e, g);
		endfunction
	endclass

	logic             clk;
	logic             arst_n    = 1'b0;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [CharW-1:0] s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [OutW-1:0]  m_tdata;
	logic [0:0]       m_tuser;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic             cfg_data  = 1'b0;

	datetime_predictor predictor;
	logic [CharW-1:0]  line_chars[$];
	mode_t             active_mode = FMT_DATE;
	bit                quiet = 1'b0;
	int unsigned       chars_sent = 0;

	date_time_string_parse_validate_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, a few long ones; none in quiet phases
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(3, 1);
		if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	// Drive one character item and hold it until accepted
	task automatic send_char(logic [CharW-1:0] c);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		chars_sent++;
	endtask

	// Send the buffered characters followed by the terminating NUL
	task automatic send_line();
		foreach (line_chars[i])
			send_char(line_chars[i]);
		send_char(ChNul);
		line_chars.delete();
	endtask

	// Drain the block, then write the format register
	task automatic write_mode(mode_t m);
		s_tvalid <= 1'b0;
		// let the monitor note the last accepted item first
		@(posedge clk);
		while (predictor.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		active_mode = m;
	endtask

	// Append one number with optional whitespace, sign, leading zeros and junk
	task automatic emit_value(int v);
		int unsigned mag_v;
		string       digits;
		if ($urandom_range(4) == 0)
			repeat ($urandom_range(2, 1))
				line_chars.push_back(($urandom_range(5) == 5) ? ChSpace
				                     : CharW'(ChTab + $urandom_range(4)));
		if (v < 0)
			line_chars.push_back(ChMinus);
		else if ($urandom_range(9) == 0)
			line_chars.push_back($urandom_range(1) ? ChPlus : ChMinus);
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(2, 1))
				line_chars.push_back(ChZero);
		mag_v = (v < 0) ? -v : v;
		digits = $sformatf("%0d", mag_v);
		if ($urandom_range(29) != 0)
			foreach (digits[i])
				line_chars.push_back(digits[i]);
		if ($urandom_range(19) == 0)
			line_chars.push_back(CharW'($urandom_range(255, 1)));
	endtask

	// Build one random string: mostly well formed, some broken, some noise
	task automatic build_line(mode_t m);
		logic [CharW-1:0] delim;
		logic [CharW-1:0] wrong;
		int               vals[3];
		int unsigned      kind;
		int unsigned      n_fields;
		int unsigned      pos;
		int               i;
		delim = (m == FMT_TIME) ? ChColon : ChDot;
		wrong = (m == FMT_TIME) ? ChDot : ChColon;
		kind = $urandom_range(99);
		if (kind < 8) begin
			repeat ($urandom_range(12, 1))
				line_chars.push_back(CharW'($urandom_range(255, 1)));
			return;
		end
		if (m == FMT_TIME) begin
			vals[0] = $urandom_range(25);
			vals[1] = $urandom_range(61);
			vals[2] = $urandom_range(61);
		end else begin
			vals[0] = $urandom_range(32);
			vals[1] = $urandom_range(13);
			case ($urandom_range(4))
				0:       vals[2] = $urandom_range(40) * 100;
				1:       vals[2] = $urandom_range(2400) & ~3;
				2:       vals[2] = -int'($urandom_range(2400));
				default: vals[2] = $urandom_range(3999);
			endcase
			// lean on the end of February
			if ($urandom_range(3) == 0) begin
				vals[1] = 2;
				vals[0] = $urandom_range(30, 27);
			end
		end
		// occasional large or negative field
		if ($urandom_range(19) == 0) begin
			pos = $urandom_range(2);
			vals[pos] = $urandom_range(9999999, 100);
		end
		if ($urandom_range(19) == 0) begin
			pos = $urandom_range(2);
			vals[pos] = -vals[pos];
		end
		n_fields = (kind < 16) ? $urandom_range(2, 1) : 3;
		for (i = 0; i < n_fields; i++) begin
			if (i != 0)
				line_chars.push_back((kind >= 16 && kind < 20) ? wrong : delim);
			emit_value(vals[i]);
		end
		// trailing delimiters and junk after the third field
		if (kind >= 20 && kind < 26) begin
			line_chars.push_back(delim);
			repeat ($urandom_range(4))
				line_chars.push_back($urandom_range(1) ? delim
				                     : CharW'($urandom_range(255, 1)));
		end
	endtask

	// Observe every handshake at the clock edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				predictor.mode = mode_t'(cfg_data);
			if (s_tvalid && s_tready)
				predictor.note_char(s_tdata);
			if (m_tvalid && m_tready)
				predictor.check_result(m_tdata, m_tuser[0]);
		end
	end

	// Result side backpressure
	initial begin
		int unsigned g;
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(8, 1)) @(posedge clk);
			g = pick_gap();
			if (g != 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	// Stimulus
	initial begin
		int unsigned phase_no;
		predictor = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty string: every field missing
		write_mode(FMT_DATE);
		send_line();
		// whitespace, negative zero, sign without digits, saturation, extra fields, top code
		line_chars = {ChTab, ChMinus, ChZero, ChDot, ChPlus, ChDot};
		repeat (7) line_chars.push_back(ChNine);
		line_chars.push_back(ChDot);
		line_chars.push_back(8'hFF);
		send_line();
		// largest valid time
		write_mode(FMT_TIME);
		line_chars = {"2", "3", ChColon, "5", "9", ChColon, "5", "9"};
		send_line();

		// random phases alternating the format, every fourth without idling
		chars_sent = 0;
		phase_no = 0;
		while (chars_sent < 1650) begin
			quiet = (phase_no % 4 == 3);
			write_mode((phase_no % 2 == 0) ? FMT_DATE : FMT_TIME);
			repeat (25) begin
				if (chars_sent < 1650) begin
					build_line(active_mode);
					send_line();
				end
			end
			phase_no++;
		end
		quiet = 1'b0;

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (predictor.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (predictor.mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Hang guard
	initial begin
		#8_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
